// ----- rtl/core/pbd_pkg.sv -----
// Shared types and constants for the run-length bitmap decoder.
// Used by the front, the queue, the back and the top level; no dependencies.
`timescale 1ns / 1ps

package pbd_pkg;

  // widths of the stream fields and the byte counter
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  // reset value of the byte limit: 576 by 720 pixels, one bit each
  localparam logic [CountW-1:0] LimitReset = CountW'((576 * 720) / 8);

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // one request from the front to the back: a data byte, its wanted
  // repeat count and the room left in the image before it is placed
  typedef struct packed {
    logic [ByteW-1:0]  pixel_bits;
    logic [ByteW-1:0]  want;
    logic [CountW-1:0] room;
  } pbd_req_t;

endpackage

// ----- rtl/core/packbits_bitmap_decoder.sv -----
// Run-length bitmap decoder for one-bit-per-pixel images.
//
// Compressed bytes enter on the in channel (in_valid/in_ready) with
// start_of_image marking the first byte of a new image. Header bytes
// produce nothing; each data byte produces one result on the out channel
// (out_valid/out_ready): the pixel byte, its repeat count and image_full.
// Once the byte limit is reached, input is swallowed until the next
// start_of_image. cfg_write_en/cfg_write_data set the limit.
//
// A data byte accepted at an edge is written into the request queue, then
// loaded into the output register, from which the receiver takes it.
// Throughput: one byte per cycle while in_ready is high; the front end
// updates its run state for every accepted byte.
//
// Reset clears the run state and byte count and sets the limit to 51840.
// When the receiver stalls, the output register and then the two-entry
// request queue fill and in_ready drops; header bytes are still taken
// while the queue has room.
// Depends on pbd_pkg, pbd_front, pbd_queue and pbd_back.
`timescale 1ns / 1ps

module packbits_bitmap_decoder
  import pbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [CountW-1:0] cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              start_of_image,
  input  logic [ByteW-1:0]  code_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ByteW-1:0]  pixel_bits,
  output logic [ByteW-1:0]  repeat_count,
  output logic              image_full
);

  logic     accept;
  logic     push;
  pbd_req_t push_req;
  logic     pop;
  logic     not_full;
  logic     not_empty;
  pbd_req_t head;

  // input request accepted while the queue has room
  assign in_ready = not_full;
  assign accept   = in_valid && not_full;

  pbd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .accept         (accept),
    .start_of_image (start_of_image),
    .code_byte      (code_byte),
    .push           (push),
    .push_req       (push_req)
  );

  pbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .not_full  (not_full),
    .not_empty (not_empty),
    .head      (head)
  );

  pbd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (not_empty),
    .req          (head),
    .req_pop      (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_bits   (pixel_bits),
    .repeat_count (repeat_count),
    .image_full   (image_full)
  );

endmodule

// ----- rtl/core/pbd_front.sv -----
// Front end: holds the byte limit, classifies each code byte as header or
// data, and keeps the run and byte-count state. Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_front
  import pbd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [CountW-1:0] cfg_write_data,
  input  logic              accept,
  input  logic              start_of_image,
  input  logic [ByteW-1:0]  code_byte,
  output logic              push,
  output pbd_req_t          push_req
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_SPARE   = 2'd3
  } phase_t;

  phase_t            phase, phase_next;
  logic [ByteW-1:0]  literal_left, literal_left_next;
  logic [ByteW-1:0]  repeat_pending, repeat_pending_next;
  logic [CountW-1:0] bytes_emitted, bytes_emitted_next;
  logic [CountW-1:0] limit;

  phase_t            cur_phase;
  logic [ByteW-1:0]  cur_literal;
  logic [ByteW-1:0]  cur_pending;
  logic [CountW-1:0] cur_emitted;
  logic [CountW-1:0] room;
  logic              full;
  logic [ByteW-1:0]  lit_dec;
  logic [CountW-1:0] clip_count;

  // start of image clears the state seen by this byte
  always_comb begin
    cur_phase   = start_of_image ? PH_HEADER : phase;
    cur_literal = start_of_image ? '0 : literal_left;
    cur_pending = start_of_image ? '0 : repeat_pending;
    cur_emitted = start_of_image ? '0 : bytes_emitted;
  end

  // room left in the image
  assign full       = (cur_emitted >= limit);
  assign room       = limit - cur_emitted;
  assign lit_dec    = cur_literal - ByteW'(1);
  assign clip_count = ({{(CountW-ByteW){1'b0}}, cur_pending} > room) ? room
                    : {{(CountW-ByteW){1'b0}}, cur_pending};

  // next state per byte class
  always_comb begin
    phase_next          = cur_phase;
    literal_left_next   = cur_literal;
    repeat_pending_next = cur_pending;
    bytes_emitted_next  = cur_emitted;
    if (!full) begin
      unique case (cur_phase)
        PH_LITERAL: begin
          bytes_emitted_next = cur_emitted + CountW'(1);
          literal_left_next  = lit_dec;
          if (lit_dec == '0) begin
            phase_next = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          bytes_emitted_next  = cur_emitted + clip_count;
          repeat_pending_next = '0;
          phase_next          = PH_HEADER;
        end
        PH_HEADER, PH_SPARE: begin
          if (code_byte != '0 && !code_byte[ByteW-1]) begin
            literal_left_next = code_byte + ByteW'(1);
            phase_next        = PH_LITERAL;
          end else begin
            // repeat count (257 - header) mod 256
            repeat_pending_next = ByteW'(1) - code_byte;
            phase_next          = PH_REPEAT;
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  // data bytes become requests for the back end
  always_comb begin
    push                = accept && !full
                          && (cur_phase == PH_LITERAL || cur_phase == PH_REPEAT);
    push_req.pixel_bits = code_byte;
    push_req.want       = (cur_phase == PH_LITERAL) ? ByteW'(1) : cur_pending;
    push_req.room       = room;
  end

  // decoder state and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      literal_left   <= '0;
      repeat_pending <= '0;
      bytes_emitted  <= '0;
      limit          <= LimitReset;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        literal_left   <= literal_left_next;
        repeat_pending <= repeat_pending_next;
        bytes_emitted  <= bytes_emitted_next;
      end
      if (cfg_write_en) begin
        limit <= cfg_write_data;
      end
    end
  end

endmodule

// ----- rtl/core/pbd_queue.sv -----
// Short first-in first-out queue of requests between front and back.
// Depends on pbd_pkg for the request type and the depth.
`timescale 1ns / 1ps

module pbd_queue
  import pbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  pbd_req_t push_req,
  input  logic     pop,
  output logic     not_full,
  output logic     not_empty,
  output pbd_req_t head
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  pbd_req_t        store [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign not_full  = (fill != CntW'(QueueDepth));
  assign not_empty = (fill != '0);
  assign head      = store[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_req;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CntW'(1);
      end else if (pop && !push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/pbd_back.sv -----
// Back end: clips each request's repeat count to the room left and holds
// the result in the output register. Depends on pbd_pkg.
`timescale 1ns / 1ps

module pbd_back
  import pbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  pbd_req_t         req,
  output logic             req_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] pixel_bits,
  output logic [ByteW-1:0] repeat_count,
  output logic             image_full
);

  logic [CountW-1:0] want_wide;
  logic [CountW-1:0] count;
  logic              load;

  // clip to the room left
  assign want_wide = {{(CountW-ByteW){1'b0}}, req.want};
  assign count     = (want_wide > req.room) ? req.room : want_wide;

  // take the next request when the output register is free
  assign load    = req_valid && (!out_valid || out_ready);
  assign req_pop = load;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_bits   <= req.pixel_bits;
      repeat_count <= count[ByteW-1:0];
      image_full   <= (count == req.room);
    end
  end

endmodule
